// ===== src/shortest_job_first_scheduler_unit_macros.svh =====
// Assertion macros for the shortest-job-first scheduler
`ifndef SHORTEST_JOB_FIRST_SCHEDULER_UNIT_MACROS_SVH
`define SHORTEST_JOB_FIRST_SCHEDULER_UNIT_MACROS_SVH
// implication checked every clock, off during reset
`define SJF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define SJF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== src/sjf_pkg.sv =====
// ----------------------------------------------------------------------------
// sjf_pkg
// Types and constants shared by the shortest-job-first scheduler.
// ----------------------------------------------------------------------------
package sjf_pkg;
	localparam int READY_DEPTH_DEF = 16;
	localparam int ID_W   = 8;
	localparam int LEN_W  = 10;
	localparam int TIME_W = 16;

	typedef enum logic [1:0] {
		ST_ACCEPTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_FUTURE   = 2'd2
	} arr_status_t;

	localparam logic MODE_ARRIVAL = 1'b0;
	localparam logic MODE_TICK    = 1'b1;

	typedef struct packed {
		logic              mode;
		logic [ID_W-1:0]   job_id;
		logic [LEN_W-1:0]  job_length;
		logic [TIME_W-1:0] job_arrival;
	} sjf_in_t;

	typedef struct packed {
		logic [1:0]        arrival_status;
		logic              running;
		logic [ID_W-1:0]   running_id;
		logic              finished;
		logic [TIME_W-1:0] finished_start;
		logic [TIME_W-1:0] finished_end;
		logic [TIME_W-1:0] tick_time;
	} sjf_out_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_SHIFT,
		BK_EMIT
	} bk_state_t;
endpackage

// ===== src/sjf_if.sv =====
// ----------------------------------------------------------------------------
// sjf_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface sjf_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== src/sjf_front.sv =====
// ----------------------------------------------------------------------------
// sjf_front
// Input queue: two-entry FIFO between the input port and the scheduler core.
// ----------------------------------------------------------------------------
module sjf_front (
	input  logic            clk,
	input  logic            arst_n,
	input  sjf_pkg::sjf_in_t in_data,
	input  logic            in_valid,
	output logic            in_ready,
	output sjf_pkg::sjf_in_t q_data,
	output logic            q_valid,
	input  logic            q_ready
);
	import sjf_pkg::*;

	sjf_in_t    mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = mem_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ===== src/sjf_back.sv =====
// ----------------------------------------------------------------------------
// sjf_back
// Scheduler core: ready table, minimum scan, compaction and result register.
// ----------------------------------------------------------------------------
module sjf_back #(
	parameter int READY_DEPTH = sjf_pkg::READY_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sjf_pkg::sjf_in_t  q_data,
	input  logic             q_valid,
	output logic             q_ready,
	output sjf_pkg::sjf_out_t out_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [$clog2(READY_DEPTH+1)-1:0] count
);
	import sjf_pkg::*;

	localparam int IW = $clog2(READY_DEPTH);
	localparam int CW = $clog2(READY_DEPTH+1);
	localparam logic [CW-1:0] DEPTH_C = CW'(READY_DEPTH);

	logic [ID_W-1:0]   ids_q  [READY_DEPTH];
	logic [LEN_W-1:0]  lens_q [READY_DEPTH];
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic [ID_W-1:0]   cur_id_q;
	logic [LEN_W-1:0]  cur_len_q, elapsed_q;
	logic [TIME_W-1:0] cur_start_q, now_q;

	logic [CW-1:0]     scan_q;     // scan cursor, then shift cursor
	logic [IW-1:0]     best_q;
	logic [LEN_W-1:0]  best_len_q;

	bk_state_t st_q, st_d;
	sjf_out_t  res_q, res_d;
	logic      res_v_q, res_set;

	logic take, need_sel;
	logic [LEN_W-1:0] el_nx;

	assign count     = cnt_q;
	assign out_data  = res_q;
	assign out_valid = res_v_q;
	assign q_ready   = (st_q == BK_IDLE) && (!res_v_q || out_ready);
	assign take      = q_valid && q_ready;
	assign need_sel  = (q_data.mode == MODE_TICK) && !busy_q && (cnt_q != '0);
	assign res_set   = (st_q == BK_EMIT) || (take && !need_sel);

	always_comb begin
		st_d = st_q;
		case (st_q)
			BK_IDLE:  if (take && need_sel) st_d = BK_SCAN;
			BK_SCAN:  if (scan_q >= cnt_q) st_d = BK_SHIFT;
			BK_SHIFT: if (scan_q + CW'(1) >= cnt_q) st_d = BK_EMIT;
			BK_EMIT:  st_d = BK_IDLE;
			default:  st_d = BK_IDLE;
		endcase
	end

	// running step on the tick (job already current)
	assign el_nx = elapsed_q + LEN_W'(1);

	always_comb begin
		res_d = '0;
		res_d.tick_time = now_q;
		if (st_q == BK_EMIT) begin
			// freshly started job runs this tick
			res_d.running = 1'b1;
			res_d.running_id = cur_id_q;
			if (cur_len_q <= LEN_W'(1)) begin
				res_d.finished = 1'b1;
				res_d.finished_start = now_q;
				res_d.finished_end = now_q;
			end
		end else if (q_data.mode == MODE_ARRIVAL) begin
			if (cnt_q >= DEPTH_C) res_d.arrival_status = ST_FULL;
			else if (q_data.job_arrival > now_q) res_d.arrival_status = ST_FUTURE;
			else res_d.arrival_status = ST_ACCEPTED;
		end else if (busy_q) begin
			res_d.running = 1'b1;
			res_d.running_id = cur_id_q;
			if (el_nx >= cur_len_q) begin
				res_d.finished = 1'b1;
				res_d.finished_start = cur_start_q;
				res_d.finished_end = now_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && q_data.mode == MODE_ARRIVAL && cnt_q < DEPTH_C
				&& q_data.job_arrival <= now_q) begin
			ids_q[cnt_q[IW-1:0]]  <= q_data.job_id;
			lens_q[cnt_q[IW-1:0]] <= q_data.job_length;
		end
		if (st_q == BK_SHIFT && scan_q + CW'(1) < cnt_q) begin
			ids_q[scan_q[IW-1:0]]  <= ids_q[scan_q[IW-1:0] + IW'(1)];
			lens_q[scan_q[IW-1:0]] <= lens_q[scan_q[IW-1:0] + IW'(1)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
			cnt_q <= '0;
			busy_q <= 1'b0;
			cur_id_q <= '0;
			cur_len_q <= '0;
			elapsed_q <= '0;
			cur_start_q <= '0;
			now_q <= '0;
			scan_q <= '0;
			best_q <= '0;
			best_len_q <= '0;
			res_v_q <= 1'b0;
			res_q <= '0;
		end else begin
			st_q <= st_d;
			res_v_q <= res_set || (res_v_q && !out_ready);
			if (res_set) res_q <= res_d;
			case (st_q)
				BK_IDLE: begin
					if (take) begin
						if (q_data.mode == MODE_ARRIVAL) begin
							if (cnt_q < DEPTH_C && q_data.job_arrival <= now_q)
								cnt_q <= cnt_q + CW'(1);
						end else if (need_sel) begin
							scan_q <= CW'(1);
							best_q <= '0;
							best_len_q <= lens_q[0];
						end else begin
							if (busy_q) begin
								elapsed_q <= el_nx;
								if (el_nx >= cur_len_q) busy_q <= 1'b0;
							end
							now_q <= now_q + TIME_W'(1);
						end
					end
				end
				BK_SCAN: begin
					if (scan_q < cnt_q) begin
						if (lens_q[scan_q[IW-1:0]] < best_len_q) begin
							best_q <= scan_q[IW-1:0];
							best_len_q <= lens_q[scan_q[IW-1:0]];
						end
						scan_q <= scan_q + CW'(1);
					end else begin
						cur_id_q <= ids_q[best_q];
						cur_len_q <= best_len_q;
						scan_q <= CW'(best_q);
					end
				end
				BK_SHIFT: begin
					if (scan_q + CW'(1) < cnt_q) scan_q <= scan_q + CW'(1);
					else cnt_q <= cnt_q - CW'(1);
				end
				BK_EMIT: begin
					cur_start_q <= now_q;
					elapsed_q <= LEN_W'(1);
					busy_q <= (cur_len_q > LEN_W'(1));
					now_q <= now_q + TIME_W'(1);
				end
				default: ;
			endcase
		end
	end
endmodule

// ===== src/shortest_job_first_scheduler_unit.sv =====
// An arrival, or a tick that starts no job, is taken from the queue head and its result registered in the next cycle.
// Throughput: one beat per cycle while no job is being started and the receiver accepts each result.
// Tick that starts a job: minimum scan over the ready entries, then compaction from the
// chosen job's table slot, one entry per cycle in each, then the result is emitted.
// A two-entry input queue lets the host keep pushing while the core works.
// Asynchronous active-low reset empties the table, clears time and the running job.
// ----------------------------------------------------------------------------
// shortest_job_first_scheduler_unit
// Non-preemptive shortest-job-first scheduler top level.
// ----------------------------------------------------------------------------
`include "shortest_job_first_scheduler_unit_macros.svh"
module shortest_job_first_scheduler_unit #(
	parameter int READY_DEPTH = sjf_pkg::READY_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	sjf_if.sink   in_ch,
	sjf_if.source out_ch
);
	import sjf_pkg::*;

	sjf_in_t q_data;
	logic    q_valid, q_ready;
	logic [$clog2(READY_DEPTH+1)-1:0] count;

	sjf_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_data(in_ch.data), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.q_data(q_data), .q_valid(q_valid), .q_ready(q_ready)
	);

	sjf_back #(.READY_DEPTH(READY_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_data(q_data), .q_valid(q_valid), .q_ready(q_ready),
		.out_data(out_ch.data), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.count(count)
	);

	`SJF_ASSERT_IMP(a_count_range, 1'b1, count <= ($clog2(READY_DEPTH+1))'(READY_DEPTH), "ready count exceeds depth")
	`SJF_ASSERT_NXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.data), "result dropped under stall")
	`SJF_ASSERT_IMP(a_fin_run, out_ch.valid && out_ch.data.finished, out_ch.data.running, "finish without run")
endmodule

// ===== tb/shortest_job_first_scheduler_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_job_first_scheduler_unit_test
// Drives arrival and tick beats into the scheduler, predicts each result with
// a local model of the ready table and running job, and checks every field.
// ----------------------------------------------------------------------------
module shortest_job_first_scheduler_unit_test;
	import sjf_pkg::*;

	localparam int DEPTH = READY_DEPTH_DEF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sjf_if #(.T(sjf_in_t))  in_ch ();
	sjf_if #(.T(sjf_out_t)) out_ch ();

	shortest_job_first_scheduler_unit #(.READY_DEPTH(DEPTH)) u_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	logic [ID_W-1:0]   tbl_id [DEPTH];
	logic [LEN_W-1:0]  tbl_len [DEPTH];
	int                tbl_count;
	logic              job_busy;
	logic [ID_W-1:0]   job_id_now;
	logic [LEN_W-1:0]  job_len_now;
	logic [LEN_W-1:0]  job_done_units;
	logic [TIME_W-1:0] job_start_t;
	logic [TIME_W-1:0] sched_time;

	sjf_in_t  pending_beats [$];
	sjf_out_t expected_results [$];
	int       errors = 0;
	int       n_results = 0;
	int       n_finished = 0;
	int       n_full = 0;
	int       stall_left = 0;
	bit       in_taken = 0;

	function automatic sjf_out_t schedule_step(sjf_in_t b);
		sjf_out_t r;
		int best;
		r = '0;
		r.tick_time = sched_time;
		if (b.mode == MODE_ARRIVAL) begin
			if (tbl_count >= DEPTH) begin
				r.arrival_status = ST_FULL;
			end else if (b.job_arrival > sched_time) begin
				r.arrival_status = ST_FUTURE;
			end else begin
				tbl_id[tbl_count] = b.job_id;
				tbl_len[tbl_count] = b.job_length;
				tbl_count++;
				r.arrival_status = ST_ACCEPTED;
			end
		end else begin
			if (!job_busy && tbl_count > 0) begin
				best = 0;
				for (int i = 1; i < tbl_count; i++)
					if (tbl_len[i] < tbl_len[best]) best = i;
				job_id_now = tbl_id[best];
				job_len_now = tbl_len[best];
				for (int i = best; i + 1 < tbl_count; i++) begin
					tbl_id[i] = tbl_id[i+1];
					tbl_len[i] = tbl_len[i+1];
				end
				tbl_count--;
				job_done_units = '0;
				job_start_t = sched_time;
				job_busy = 1'b1;
			end
			if (job_busy) begin
				r.running = 1'b1;
				r.running_id = job_id_now;
				job_done_units = job_done_units + 1'b1;
				if (job_done_units >= job_len_now) begin
					r.finished = 1'b1;
					r.finished_start = job_start_t;
					r.finished_end = sched_time;
					job_busy = 1'b0;
				end
			end
			sched_time = sched_time + 1'b1;
		end
		return r;
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, n_results);
		errors++;
	endtask

	// input handshake seen at the rising edge
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			expected_results.push_back(schedule_step(in_ch.data));
			void'(pending_beats.pop_front());
			in_taken = 1'b1;
		end
	end

	// driver: bursts and gaps, one beat per handshake
	int gap_left = 0;
	int burst_left = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_ch.valid || in_taken) begin
				in_taken = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
					in_ch.valid <= 1'b0;
				end else if (pending_beats.size() > 0) begin
					in_ch.valid <= 1'b1;
					in_ch.data <= pending_beats[0];
					if (burst_left > 0) burst_left--;
					else begin
						burst_left = $urandom_range(0, 20);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
					end
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: own stall pattern, plus a long hold-off counted here
	int stall_pat = 0;
	always @(negedge clk) begin
		if (!arst_n) out_ch.ready <= 1'b0;
		else if (stall_left > 0) begin
			stall_left--;
			out_ch.ready <= 1'b0;
		end else begin
			stall_pat = (stall_pat + 1) % 11;
			out_ch.ready <= ($urandom_range(0, 3) != 0) && (stall_pat != 3);
		end
	end

	// monitor
	always @(posedge clk) begin
		sjf_out_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			n_results++;
			if (expected_results.size() == 0) begin
				$display("unexpected result beat %0d", n_results);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (out_ch.data.arrival_status != want.arrival_status)
					report("arrival_status", out_ch.data.arrival_status, want.arrival_status);
				if (out_ch.data.running != want.running)
					report("running", out_ch.data.running, want.running);
				if (out_ch.data.running_id != want.running_id)
					report("running_id", out_ch.data.running_id, want.running_id);
				if (out_ch.data.finished != want.finished)
					report("finished", out_ch.data.finished, want.finished);
				if (out_ch.data.finished_start != want.finished_start)
					report("finished_start", out_ch.data.finished_start, want.finished_start);
				if (out_ch.data.finished_end != want.finished_end)
					report("finished_end", out_ch.data.finished_end, want.finished_end);
				if (out_ch.data.tick_time != want.tick_time)
					report("tick_time", out_ch.data.tick_time, want.tick_time);
				if (want.finished) n_finished++;
				if (want.arrival_status == ST_FULL) n_full++;
			end
		end
	end

	function automatic sjf_in_t mk(logic m, int id, int len, int arr);
		sjf_in_t b;
		b.mode = m;
		b.job_id = ID_W'(id);
		b.job_length = LEN_W'(len);
		b.job_arrival = TIME_W'(arr);
		return b;
	endfunction

	// arrival time mostly no later than the predicted clock
	int est_time = 0;
	task automatic add_arrival(int len);
		int arr;
		if ($urandom_range(0, 9) == 0) arr = $urandom_range(0, 65535);
		else arr = (est_time > 0) ? $urandom_range(0, est_time) : 0;
		pending_beats.push_back(mk(MODE_ARRIVAL, $urandom_range(0, 255), len, arr));
	endtask

	task automatic add_tick();
		pending_beats.push_back(mk(MODE_TICK, $urandom_range(0, 255),
			$urandom_range(0, 1023), $urandom_range(0, 65535)));
		est_time++;
	endtask

	task automatic drain();
		while (pending_beats.size() > 0 || in_ch.valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	initial begin
		tbl_count = 0;
		job_busy = 0;
		job_id_now = '0;
		job_len_now = '0;
		job_done_units = '0;
		job_start_t = '0;
		sched_time = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: future, equal time, zero length, extremes, tie, overflow
		pending_beats.push_back(mk(MODE_ARRIVAL, 8'hff, 10'h3ff, 16'hffff));
		pending_beats.push_back(mk(MODE_ARRIVAL, 0, 0, 0));
		pending_beats.push_back(mk(MODE_ARRIVAL, 255, 1023, 0));
		pending_beats.push_back(mk(MODE_ARRIVAL, 7, 1, 0));
		pending_beats.push_back(mk(MODE_ARRIVAL, 8, 1, 0));
		repeat (3) add_tick();
		pending_beats.push_back(mk(MODE_ARRIVAL, 9, 2, 3));
		pending_beats.push_back(mk(MODE_ARRIVAL, 10, 2, 4));
		for (int i = 0; i < 16; i++)
			pending_beats.push_back(mk(MODE_ARRIVAL, i, 5 + i % 3, 1));
		pending_beats.push_back(mk(MODE_ARRIVAL, 99, 3, 16'hffff));
		drain();

		// long receiver stall while the sender keeps pushing
		for (int i = 0; i < 40; i++) add_tick();
		stall_left = 300;
		wait (stall_left == 0);
		drain();

		// random well-formed traffic: short jobs, mostly ticks
		for (int i = 0; i < 900; i++) begin
			if ($urandom_range(0, 2) == 0) add_arrival($urandom_range(0, 6));
			else if ($urandom_range(0, 40) == 0) add_arrival($urandom_range(0, 1023));
			else add_tick();
			// sender goes quiet until every expected result is back
			if (i == 450) drain();
		end
		drain();

		$display("covered %0d results, %0d jobs finished, %0d table-full drops",
			n_results, n_finished, n_full);
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

	initial begin
		#20ms;
		$display("timeout");
		$display("DONE: errors detected");
		$finish;
	end
endmodule

// ===== shortest_job_first_scheduler_unit.f =====
+incdir+src
src/sjf_pkg.sv
src/sjf_if.sv
src/sjf_front.sv
src/sjf_back.sv
src/shortest_job_first_scheduler_unit.sv
tb/shortest_job_first_scheduler_unit_test.sv
